// ===== rtl/mdcf_pkg.sv =====
// ----------------------------------------------------------------------------
// mdcf_pkg: shared types and constants of the drive command framer
// Command and status groups between controller and datapath, frame codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdcf_pkg;

    // command kinds
    localparam logic [1:0] KIND_ENABLE  = 2'd0;
    localparam logic [1:0] KIND_MODE    = 2'd1;
    localparam logic [1:0] KIND_PROFILE = 2'd2;
    localparam logic [1:0] KIND_TARGET  = 2'd3;

    // drive selector codes
    localparam logic [1:0] SEL_LEFT  = 2'd1;
    localparam logic [1:0] SEL_RIGHT = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_ADDR  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_ADDR = 2'd1;
    localparam logic [1:0] CFG_POS_GAIN   = 2'd2;

    // modbus function codes and object bytes
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_WRITE_MULTI  = 8'h10;
    localparam logic [7:0] OBJ_HI          = 8'h60;
    localparam logic [7:0] OBJ_CONTROL     = 8'h40;
    localparam logic [7:0] OBJ_MODE        = 8'h60;
    localparam logic [7:0] OBJ_PROFILE     = 8'h81;
    localparam logic [7:0] OBJ_TARGET      = 8'h7A;
    localparam logic [7:0] CW_ENABLE       = 8'h0F;
    localparam logic [7:0] CW_SWITCH       = 8'h3F;

    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;

    // body lengths in bytes
    localparam logic [4:0] LEN_SHORT   = 5'd6;
    localparam logic [4:0] LEN_PROFILE = 5'd15;
    localparam logic [4:0] LEN_TARGET  = 5'd11;

    typedef struct packed {
        logic load;
        logic fix;
        logic emit_body;
        logic crc_step;
        logic emit_crc_lo;
        logic emit_crc_hi;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic body_done;
        logic last_frame;
    } t_status;

endpackage

// ===== rtl/modbus_drive_command_framer_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_drive_command_framer_unit: drive command to modbus rtu request bytes
// Each command is scaled first; then every body byte is emitted and followed by
// an 8-step serial crc, and the crc low and high bytes close each frame of a run.
// Sync active-low reset clears control state and loads register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_drive_command_framer_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [1:0]         i_drive_select,
    input  logic [7:0]         i_mode_value,
    input  logic [7:0]         i_speed_value,
    input  logic [7:0]         i_accel_value,
    input  logic [7:0]         i_decel_value,
    input  logic signed [15:0] i_target_angle,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_frame_byte,
    output logic               o_end_of_frame,
    output logic               o_end_of_run
);

    mdcf_pkg::t_cmd    w_cmd;
    mdcf_pkg::t_status w_status;

    mdcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mdcf_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_drive_select (i_drive_select),
        .i_mode_value   (i_mode_value),
        .i_speed_value  (i_speed_value),
        .i_accel_value  (i_accel_value),
        .i_decel_value  (i_decel_value),
        .i_target_angle (i_target_angle),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_end_of_frame (o_end_of_frame),
        .o_end_of_run   (o_end_of_run)
    );

`ifndef SYNTH
    a_eor_closes_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_end_of_run |-> o_end_of_frame)
        else $error("end of run without end of frame");

    a_one_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load, w_cmd.fix, w_cmd.emit_body, w_cmd.crc_step,
                  w_cmd.emit_crc_lo, w_cmd.emit_crc_hi}))
        else $error("more than one datapath action");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after input transfer");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit_body || w_cmd.emit_crc_lo || w_cmd.emit_crc_hi |-> w_status.out_free)
        else $error("output register overwritten");
`endif

endmodule

// ===== rtl/mdcf_ctrl.sv =====
// ----------------------------------------------------------------------------
// mdcf_ctrl: framer sequencer
// Steps one command through scaling, body bytes, bit-serial crc and crc bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdcf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  mdcf_pkg::t_status i_status,
    output mdcf_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_BODY = 3'd3;
    localparam logic [2:0] S_CRC  = 3'd4;
    localparam logic [2:0] S_CLO  = 3'd5;
    localparam logic [2:0] S_CHI  = 3'd6;

    logic [2:0] r_state, n_state;
    logic [2:0] r_bit, n_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_bit   <= n_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        n_bit   = r_bit;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_BODY;
            end
            S_BODY: begin
                if (i_status.out_free) begin
                    o_cmd.emit_body = 1'b1;
                    n_bit           = 3'd0;
                    n_state         = S_CRC;
                end
            end
            S_CRC: begin
                o_cmd.crc_step = 1'b1;
                n_bit          = r_bit + 3'd1;
                if (r_bit == 3'd7) begin
                    n_state = i_status.body_done ? S_CLO : S_BODY;
                end
            end
            S_CLO: begin
                if (i_status.out_free) begin
                    o_cmd.emit_crc_lo = 1'b1;
                    n_state           = S_CHI;
                end
            end
            S_CHI: begin
                if (i_status.out_free) begin
                    o_cmd.emit_crc_hi = 1'b1;
                    n_state           = i_status.last_frame ? S_IDLE : S_BODY;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/mdcf_dp.sv =====
// ----------------------------------------------------------------------------
// mdcf_dp: framer datapath
// Config registers, held command, position scaling, crc and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdcf_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_kind,
    input  logic [1:0]         i_drive_select,
    input  logic [7:0]         i_mode_value,
    input  logic [7:0]         i_speed_value,
    input  logic [7:0]         i_accel_value,
    input  logic [7:0]         i_decel_value,
    input  logic signed [15:0] i_target_angle,
    input  mdcf_pkg::t_cmd     i_cmd,
    output mdcf_pkg::t_status  o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [7:0]         o_frame_byte,
    output logic               o_end_of_frame,
    output logic               o_end_of_run
);

    logic [7:0]         r_left_addr;
    logic [7:0]         r_right_addr;
    logic [15:0]        r_gain;
    logic [1:0]         r_kind;
    logic [7:0]         r_mode;
    logic [7:0]         r_speed;
    logic [7:0]         r_accel;
    logic [7:0]         r_decel;
    logic [7:0]         r_addr;
    logic               r_multi;
    logic signed [15:0] r_angle;
    logic signed [32:0] r_prod;
    logic [31:0]        r_position;
    logic [15:0]        r_crc;
    logic [4:0]         r_pos;
    logic [1:0]         r_frame;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic               r_out_eof;
    logic               r_out_eor;

    logic signed [32:0] w_rounded;
    logic signed [32:0] w_shifted;
    logic [7:0]         w_body;
    logic [4:0]         w_len;
    logic [7:0]         w_word;
    logic               w_short;
    logic               w_last_frame;
    logic [15:0]        w_crc_in;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_addr  <= 8'd3;
            r_right_addr <= 8'd4;
            r_gain       <= 16'd35;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mdcf_pkg::CFG_LEFT_ADDR:  r_left_addr  <= i_cfg_data[7:0];
                mdcf_pkg::CFG_RIGHT_ADDR: r_right_addr <= i_cfg_data[7:0];
                mdcf_pkg::CFG_POS_GAIN:   r_gain       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // held command
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_kind;
            r_mode  <= i_mode_value;
            r_speed <= i_speed_value;
            r_accel <= i_accel_value;
            r_decel <= i_decel_value;
            r_angle <= i_target_angle;
            r_multi <= (i_kind == mdcf_pkg::KIND_TARGET) &&
                       ((i_drive_select == mdcf_pkg::SEL_LEFT) ||
                        (i_drive_select == mdcf_pkg::SEL_RIGHT));
            if (i_drive_select == mdcf_pkg::SEL_LEFT) begin
                r_addr <= r_left_addr;
            end else if (i_drive_select == mdcf_pkg::SEL_RIGHT) begin
                r_addr <= r_right_addr;
            end else begin
                r_addr <= 8'h00;
            end
        end
    end

    // position scaling, truncation toward zero
    always_ff @(posedge i_clk) begin
        r_prod <= 33'(r_angle) * 33'($signed({1'b0, r_gain}));
    end

    assign w_rounded = r_prod + (r_prod[32] ? 33'sd255 : 33'sd0);
    assign w_shifted = w_rounded >>> 8;

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix) begin
            r_position <= w_shifted[31:0];
        end
    end

    // body byte selection
    assign w_short = (r_frame != 2'd0) || (r_kind == mdcf_pkg::KIND_ENABLE) ||
                     (r_kind == mdcf_pkg::KIND_MODE);
    assign w_word  = (r_frame == 2'd1) ? mdcf_pkg::CW_SWITCH : mdcf_pkg::CW_ENABLE;

    always_comb begin
        w_body = 8'h00;
        w_len  = mdcf_pkg::LEN_SHORT;
        if (w_short) begin
            case (r_pos)
                5'd0: w_body = r_addr;
                5'd1: w_body = mdcf_pkg::FC_WRITE_SINGLE;
                5'd2: w_body = mdcf_pkg::OBJ_HI;
                5'd3: w_body = (r_frame == 2'd0 && r_kind == mdcf_pkg::KIND_MODE) ?
                               mdcf_pkg::OBJ_MODE : mdcf_pkg::OBJ_CONTROL;
                5'd5: w_body = (r_frame == 2'd0 && r_kind == mdcf_pkg::KIND_MODE) ?
                               r_mode : w_word;
                default: w_body = 8'h00;
            endcase
        end else if (r_kind == mdcf_pkg::KIND_PROFILE) begin
            w_len = mdcf_pkg::LEN_PROFILE;
            case (r_pos)
                5'd0:  w_body = r_addr;
                5'd1:  w_body = mdcf_pkg::FC_WRITE_MULTI;
                5'd2:  w_body = mdcf_pkg::OBJ_HI;
                5'd3:  w_body = mdcf_pkg::OBJ_PROFILE;
                5'd5:  w_body = 8'h04;
                5'd6:  w_body = 8'h08;
                5'd10: w_body = r_speed;
                5'd12: w_body = r_accel;
                5'd14: w_body = r_decel;
                default: w_body = 8'h00;
            endcase
        end else begin
            w_len = mdcf_pkg::LEN_TARGET;
            case (r_pos)
                5'd0:  w_body = r_addr;
                5'd1:  w_body = mdcf_pkg::FC_WRITE_MULTI;
                5'd2:  w_body = mdcf_pkg::OBJ_HI;
                5'd3:  w_body = mdcf_pkg::OBJ_TARGET;
                5'd5:  w_body = 8'h02;
                5'd6:  w_body = 8'h04;
                5'd7:  w_body = r_position[31:24];
                5'd8:  w_body = r_position[23:16];
                5'd9:  w_body = r_position[15:8];
                5'd10: w_body = r_position[7:0];
                default: w_body = 8'h00;
            endcase
        end
    end

    assign w_last_frame = r_multi ? (r_frame == 2'd2) : (r_frame == 2'd0);
    assign w_crc_in     = r_crc ^ {8'h00, w_body};

    // crc, byte position and frame counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc   <= mdcf_pkg::CRC_PRESET;
            r_pos   <= 5'd0;
            r_frame <= 2'd0;
        end else if (i_cmd.load) begin
            r_crc   <= mdcf_pkg::CRC_PRESET;
            r_pos   <= 5'd0;
            r_frame <= 2'd0;
        end else if (i_cmd.emit_body) begin
            r_crc <= w_crc_in;
            r_pos <= r_pos + 5'd1;
        end else if (i_cmd.crc_step) begin
            r_crc <= r_crc[0] ? ((r_crc >> 1) ^ mdcf_pkg::CRC_POLY) : (r_crc >> 1);
        end else if (i_cmd.emit_crc_hi) begin
            r_crc   <= mdcf_pkg::CRC_PRESET;
            r_pos   <= 5'd0;
            r_frame <= w_last_frame ? 2'd0 : r_frame + 2'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_body || i_cmd.emit_crc_lo || i_cmd.emit_crc_hi) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_body) begin
            r_out_byte <= w_body;
            r_out_eof  <= 1'b0;
            r_out_eor  <= 1'b0;
        end else if (i_cmd.emit_crc_lo) begin
            r_out_byte <= r_crc[7:0];
            r_out_eof  <= 1'b0;
            r_out_eor  <= 1'b0;
        end else if (i_cmd.emit_crc_hi) begin
            r_out_byte <= r_crc[15:8];
            r_out_eof  <= 1'b1;
            r_out_eor  <= w_last_frame;
        end
    end

    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.body_done  = (r_pos == w_len);
    assign o_status.last_frame = w_last_frame;

    assign o_out_valid    = r_out_valid;
    assign o_frame_byte   = r_out_byte;
    assign o_end_of_frame = r_out_eof;
    assign o_end_of_run   = r_out_eor;

endmodule

// ===== tb/sv/modbus_drive_command_framer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// modbus_drive_command_framer_unit_tb: request framing and crc check
// Drives drive commands through the valid/ready input, predicts every frame
// byte with its crc and end flags, and compares each output transfer in order
// under several sender and receiver idle mixes and register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_drive_command_framer_unit_tb;

    localparam logic [1:0] SEL_NONE      = 2'd0;
    localparam logic [1:0] SEL_SPARE     = 2'd3;
    localparam logic [1:0] CFG_UNUSED    = 2'd3;
    localparam logic [7:0] TARGET_REGS   = 8'h02;
    localparam logic [7:0] TARGET_BYTES  = 8'h04;
    localparam logic [7:0] PROFILE_REGS  = 8'h04;
    localparam logic [7:0] PROFILE_BYTES = 8'h08;
    localparam int         RUN_CYCLES    = 250;
    localparam int         CYCLE_LIMIT   = 600000;

    typedef struct {
        logic [1:0]         kind;
        logic [1:0]         sel;
        logic [7:0]         mode;
        logic [7:0]         speed;
        logic [7:0]         accel;
        logic [7:0]         decel;
        logic signed [15:0] angle;
    } t_drive_cmd;

    typedef struct {
        logic [7:0] data;
        logic       eof;
        logic       eor;
    } t_line_byte;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_kind;
    logic [1:0]         i_drive_select;
    logic [7:0]         i_mode_value;
    logic [7:0]         i_speed_value;
    logic [7:0]         i_accel_value;
    logic [7:0]         i_decel_value;
    logic signed [15:0] i_target_angle;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [7:0]         o_frame_byte;
    logic               o_end_of_frame;
    logic               o_end_of_run;

    logic [7:0]  left_addr_reg;
    logic [7:0]  right_addr_reg;
    logic [15:0] gain_reg;

    t_line_byte  pending_bytes[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          sender_idle_pct = 0;
    int          receiver_stall_pct = 0;

    modbus_drive_command_framer_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_kind         (i_kind),
        .i_drive_select (i_drive_select),
        .i_mode_value   (i_mode_value),
        .i_speed_value  (i_speed_value),
        .i_accel_value  (i_accel_value),
        .i_decel_value  (i_decel_value),
        .i_target_angle (i_target_angle),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_end_of_frame (o_end_of_frame),
        .o_end_of_run   (o_end_of_run)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes outstanding", $time, pending_bytes.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // frame byte checker
    always @(posedge i_clk) begin
        t_line_byte exp_byte;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte %02h eof %0b eor %0b", $time,
                         o_frame_byte, o_end_of_frame, o_end_of_run);
                error_count++;
            end else begin
                exp_byte = pending_bytes.pop_front();
                if (o_frame_byte !== exp_byte.data) begin
                    $display("%0t: frame_byte expected %02h actual %02h", $time,
                             exp_byte.data, o_frame_byte);
                    error_count++;
                end
                if (o_end_of_frame !== exp_byte.eof) begin
                    $display("%0t: end_of_frame expected %0b actual %0b", $time,
                             exp_byte.eof, o_end_of_frame);
                    error_count++;
                end
                if (o_end_of_run !== exp_byte.eor) begin
                    $display("%0t: end_of_run expected %0b actual %0b", $time,
                             exp_byte.eor, o_end_of_run);
                    error_count++;
                end
            end
        end
    end

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ mdcf_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic void queue_frame(input logic [7:0] body [0:16], input int len,
                                        input bit closes_run);
        logic [15:0] crc;
        t_line_byte  lb;
        crc = mdcf_pkg::CRC_PRESET;
        for (int i = 0; i < len; i++) begin
            crc = crc16_byte(crc, body[i]);
            lb = '{data: body[i], eof: 1'b0, eor: 1'b0};
            pending_bytes.push_back(lb);
        end
        lb = '{data: crc[7:0], eof: 1'b0, eor: 1'b0};
        pending_bytes.push_back(lb);
        lb = '{data: crc[15:8], eof: 1'b1, eor: closes_run};
        pending_bytes.push_back(lb);
    endfunction

    function automatic void predict_frames(input t_drive_cmd c);
        logic [7:0]  body [0:16];
        logic [7:0]  addr;
        logic [31:0] pos;
        longint      product;
        bit          follow;
        addr = (c.sel == mdcf_pkg::SEL_LEFT) ? left_addr_reg :
               (c.sel == mdcf_pkg::SEL_RIGHT) ? right_addr_reg : 8'h00;
        follow = (c.kind == mdcf_pkg::KIND_TARGET) &&
                 (c.sel == mdcf_pkg::SEL_LEFT || c.sel == mdcf_pkg::SEL_RIGHT);
        body = '{default: 8'h00};
        body[0] = addr;
        case (c.kind)
            mdcf_pkg::KIND_ENABLE: begin
                body[1] = mdcf_pkg::FC_WRITE_SINGLE;
                body[2] = mdcf_pkg::OBJ_HI;
                body[3] = mdcf_pkg::OBJ_CONTROL;
                body[5] = mdcf_pkg::CW_ENABLE;
                queue_frame(body, int'(mdcf_pkg::LEN_SHORT), 1'b1);
            end
            mdcf_pkg::KIND_MODE: begin
                body[1] = mdcf_pkg::FC_WRITE_SINGLE;
                body[2] = mdcf_pkg::OBJ_HI;
                body[3] = mdcf_pkg::OBJ_MODE;
                body[5] = c.mode;
                queue_frame(body, int'(mdcf_pkg::LEN_SHORT), 1'b1);
            end
            mdcf_pkg::KIND_PROFILE: begin
                body[1]  = mdcf_pkg::FC_WRITE_MULTI;
                body[2]  = mdcf_pkg::OBJ_HI;
                body[3]  = mdcf_pkg::OBJ_PROFILE;
                body[5]  = PROFILE_REGS;
                body[6]  = PROFILE_BYTES;
                body[10] = c.speed;
                body[12] = c.accel;
                body[14] = c.decel;
                queue_frame(body, int'(mdcf_pkg::LEN_PROFILE), 1'b1);
            end
            default: begin
                // signed product, divided with truncation toward zero
                product = longint'(c.angle) * longint'(gain_reg);
                product = product / 256;
                pos = product[31:0];
                body[1]  = mdcf_pkg::FC_WRITE_MULTI;
                body[2]  = mdcf_pkg::OBJ_HI;
                body[3]  = mdcf_pkg::OBJ_TARGET;
                body[5]  = TARGET_REGS;
                body[6]  = TARGET_BYTES;
                body[7]  = pos[31:24];
                body[8]  = pos[23:16];
                body[9]  = pos[15:8];
                body[10] = pos[7:0];
                queue_frame(body, int'(mdcf_pkg::LEN_TARGET), !follow);
                if (follow) begin
                    body = '{default: 8'h00};
                    body[0] = addr;
                    body[1] = mdcf_pkg::FC_WRITE_SINGLE;
                    body[2] = mdcf_pkg::OBJ_HI;
                    body[3] = mdcf_pkg::OBJ_CONTROL;
                    body[5] = mdcf_pkg::CW_SWITCH;
                    queue_frame(body, int'(mdcf_pkg::LEN_SHORT), 1'b0);
                    body[5] = mdcf_pkg::CW_ENABLE;
                    queue_frame(body, int'(mdcf_pkg::LEN_SHORT), 1'b1);
                end
            end
        endcase
    endfunction

    function automatic t_drive_cmd make_cmd(input logic [1:0] kind, input logic [1:0] sel,
                                            input logic [7:0] mode, input logic [7:0] speed,
                                            input logic [7:0] accel, input logic [7:0] decel,
                                            input logic signed [15:0] angle);
        t_drive_cmd c;
        c.kind  = kind;
        c.sel   = sel;
        c.mode  = mode;
        c.speed = speed;
        c.accel = accel;
        c.decel = decel;
        c.angle = angle;
        return c;
    endfunction

    function automatic t_drive_cmd random_cmd();
        t_drive_cmd c;
        c.kind = 2'($urandom_range(3));
        if ($urandom_range(9) < 8) begin
            c.sel = $urandom_range(1) ? mdcf_pkg::SEL_LEFT : mdcf_pkg::SEL_RIGHT;
        end else begin
            c.sel = $urandom_range(1) ? SEL_NONE : SEL_SPARE;
        end
        c.mode  = 8'($urandom);
        c.speed = 8'($urandom);
        c.accel = 8'($urandom);
        c.decel = 8'($urandom);
        if ($urandom_range(3) == 0) begin
            c.angle = 16'($urandom_range(1023)) - 16'sd512;
        end else begin
            c.angle = 16'($urandom);
        end
        return c;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            mdcf_pkg::CFG_LEFT_ADDR:  left_addr_reg  = data[7:0];
            mdcf_pkg::CFG_RIGHT_ADDR: right_addr_reg = data[7:0];
            mdcf_pkg::CFG_POS_GAIN:   gain_reg       = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_cmd(input t_drive_cmd c);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind         = c.kind;
        i_drive_select = c.sel;
        i_mode_value   = c.mode;
        i_speed_value  = c.speed;
        i_accel_value  = c.accel;
        i_decel_value  = c.decel;
        i_target_angle = c.angle;
        i_in_valid     = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_frames(c);
    endtask

    // drop valid and let every predicted byte come out
    task automatic drain_frames();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_reset_values();
        send_cmd(make_cmd(mdcf_pkg::KIND_ENABLE, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_ENABLE, mdcf_pkg::SEL_RIGHT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_RIGHT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd256));
        drain_frames();
    endtask

    task automatic test_each_command();
        write_reg(mdcf_pkg::CFG_LEFT_ADDR, 16'd0);
        write_reg(mdcf_pkg::CFG_RIGHT_ADDR, 16'd247);
        send_cmd(make_cmd(mdcf_pkg::KIND_ENABLE, SEL_NONE,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_MODE, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'hFF, 8'hFF, 8'hFF, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_MODE, mdcf_pkg::SEL_RIGHT,
                          8'hFF, 8'h00, 8'h00, 8'h00, -16'sd1));
        send_cmd(make_cmd(mdcf_pkg::KIND_PROFILE, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h80, 8'h00, 8'hFF, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_PROFILE, SEL_SPARE,
                          8'h00, 8'h7F, 8'hFF, 8'h00, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_ENABLE, SEL_SPARE,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd0));
        drain_frames();
    endtask

    task automatic test_target_scaling();
        write_reg(mdcf_pkg::CFG_POS_GAIN, 16'hFFFF);
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sh7FFF));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sh8000));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_RIGHT,
                          8'h00, 8'h00, 8'h00, 8'h00, -16'sd1));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, SEL_NONE,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd1));
        drain_frames();
        write_reg(mdcf_pkg::CFG_POS_GAIN, 16'd0);
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sh8000));
        drain_frames();
        write_reg(mdcf_pkg::CFG_POS_GAIN, 16'd1);
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_RIGHT,
                          8'h00, 8'h00, 8'h00, 8'h00, -16'sd255));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, SEL_SPARE,
                          8'h00, 8'h00, 8'h00, 8'h00, -16'sd257));
        drain_frames();
        write_reg(mdcf_pkg::CFG_POS_GAIN, 16'd35);
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, -16'sd100));
        drain_frames();
    endtask

    task automatic test_address_edges();
        write_reg(mdcf_pkg::CFG_LEFT_ADDR, 16'h00FF);
        write_reg(mdcf_pkg::CFG_RIGHT_ADDR, 16'hFFF8);
        write_reg(CFG_UNUSED, 16'hFFFF);
        send_cmd(make_cmd(mdcf_pkg::KIND_ENABLE, mdcf_pkg::SEL_LEFT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sd0));
        send_cmd(make_cmd(mdcf_pkg::KIND_TARGET, mdcf_pkg::SEL_RIGHT,
                          8'h00, 8'h00, 8'h00, 8'h00, 16'sh7FFF));
        drain_frames();
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
        logic [15:0] pick;
        drain_frames();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        case ($urandom_range(3))
            0:       pick = 16'd0;
            1:       pick = 16'd247;
            2:       pick = 16'd255;
            default: pick = 16'($urandom);
        endcase
        write_reg(mdcf_pkg::CFG_LEFT_ADDR, pick);
        write_reg(mdcf_pkg::CFG_RIGHT_ADDR, 16'($urandom_range(255)));
        case ($urandom_range(3))
            0:       pick = 16'd0;
            1:       pick = 16'd1;
            2:       pick = 16'hFFFF;
            default: pick = 16'($urandom);
        endcase
        write_reg(mdcf_pkg::CFG_POS_GAIN, pick);
        if ($urandom_range(1)) begin
            write_reg(CFG_UNUSED, 16'($urandom));
        end
        for (int n = 0; n < count; n++) begin
            send_cmd(random_cmd());
            if ($urandom_range(19) == 0) begin
                drain_frames();
            end
        end
        drain_frames();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = mdcf_pkg::CFG_LEFT_ADDR;
        i_cfg_data     = 16'd0;
        i_in_valid     = 1'b0;
        i_kind         = mdcf_pkg::KIND_ENABLE;
        i_drive_select = SEL_NONE;
        i_mode_value   = 8'h00;
        i_speed_value  = 8'h00;
        i_accel_value  = 8'h00;
        i_decel_value  = 8'h00;
        i_target_angle = 16'sd0;
        left_addr_reg  = 8'd3;
        right_addr_reg = 8'd4;
        gain_reg       = 16'd35;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_values();
        test_each_command();
        test_target_scaling();
        test_address_edges();
        test_random_traffic(60, 0, 0);
        test_random_traffic(60, 65, 0);
        test_random_traffic(60, 0, 65);
        test_random_traffic(60, 28, 28);

        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (RUN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mdcf_pkg.sv
rtl/mdcf_ctrl.sv
rtl/mdcf_dp.sv
rtl/modbus_drive_command_framer_unit.sv
tb/sv/modbus_drive_command_framer_unit_tb.sv
